### hw/rtl/lzwd_pkg.sv
// Types and constants shared by the LZW decoder modules.
`default_nettype none
package lzwd_pkg;

    localparam int CODE_BITS = 12;
    localparam int BYTES_PER_RESULT = 64;

    localparam logic [12:0] CODE_CLEAR = 13'd256;
    localparam logic [12:0] CODE_END = 13'd257;
    localparam logic [12:0] CODE_FIRST = 13'd258;
    localparam logic [3:0] START_WIDTH = 4'd9;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_OK = 2'd1,
        ST_CORRUPT = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        H_DECODING = 2'd0,
        H_ENDED = 2'd1,
        H_CORRUPT = 2'd2
    } halt_t;

    typedef enum logic {
        CMD_EXPAND = 1'b0,
        CMD_STATUS = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic end_of_input;
    } in_t;

    typedef struct packed {
        logic [63:0] out_word_0;
        logic [63:0] out_word_1;
        logic [63:0] out_word_2;
        logic [63:0] out_word_3;
        logic [63:0] out_word_4;
        logic [63:0] out_word_5;
        logic [63:0] out_word_6;
        logic [63:0] out_word_7;
        logic [6:0] byte_count;
        logic last_of_run;
        logic [1:0] final_status;
        logic [31:0] total_bytes;
    } out_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic kwkwk;
        logic add;
        logic [CODE_BITS-1:0] walk_code;
        logic [CODE_BITS-1:0] add_addr;
        logic [CODE_BITS-1:0] add_prefix;
        status_t status;
    } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/lzwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lzwd_front.sv
// Front end: bit unpacking, code classification and dictionary bookkeeping.
`default_nettype none
module lzwd_front import lzwd_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  in_t       item,
    output logic      cmd_push,
    output cmd_t      cmd
);

    logic [19:0] bitbuf_reg, bitbuf_next;
    logic [4:0]  bitcnt_reg, bitcnt_next;
    logic [12:0] next_code_reg, next_code_next;
    logic [3:0]  width_reg, width_next;
    logic [CODE_BITS-1:0] prev_reg, prev_next;
    logic        prev_valid_reg, prev_valid_next;
    halt_t       halt_reg, halt_next;

    logic [19:0] buf_sh;
    logic [4:0]  cnt_sh;
    logic [4:0]  shift;
    logic [19:0] code_wide;
    logic [CODE_BITS-1:0] code;
    logic [12:0] code13;
    logic [12:0] nc_after;
    logic        add;
    logic        kwkwk;

    always_comb
    begin
        buf_sh = {bitbuf_reg[11:0], item.in_byte};
        cnt_sh = bitcnt_reg + 5'd8;
        shift = cnt_sh - {1'b0, width_reg};
        code_wide = buf_sh >> shift;
        code = code_wide[CODE_BITS-1:0] & ((CODE_BITS'(1) << width_reg) - CODE_BITS'(1));
        code13 = {1'b0, code};
        kwkwk = (code13 == next_code_reg);
        add = 1'b0;
        nc_after = next_code_reg;

        bitbuf_next = bitbuf_reg;
        bitcnt_next = bitcnt_reg;
        next_code_next = next_code_reg;
        width_next = width_reg;
        prev_next = prev_reg;
        prev_valid_next = prev_valid_reg;
        halt_next = halt_reg;
        cmd_push = 1'b0;
        cmd = '0;
        cmd.kind = CMD_EXPAND;
        cmd.status = ST_RUNNING;

        if (accept)
        begin
            if (item.end_of_input)
            begin
                cmd_push = 1'b1;
                cmd.kind = CMD_STATUS;
                unique case (halt_reg)
                    H_ENDED:   cmd.status = ST_OK;
                    H_CORRUPT: cmd.status = ST_CORRUPT;
                    default:   cmd.status = ST_TRUNCATED;
                endcase
                bitbuf_next = '0;
                bitcnt_next = '0;
                next_code_next = CODE_FIRST;
                width_next = START_WIDTH;
                prev_valid_next = 1'b0;
                halt_next = H_DECODING;
            end
            else if (halt_reg == H_DECODING)
            begin
                bitbuf_next = buf_sh;
                bitcnt_next = cnt_sh;
                if (cnt_sh >= {1'b0, width_reg})
                begin
                    bitcnt_next = shift;
                    bitbuf_next = buf_sh & ((20'(1) << shift) - 20'(1));
                    if (code13 == CODE_END)
                    begin
                        halt_next = H_ENDED;
                    end
                    else if (code13 == CODE_CLEAR)
                    begin
                        next_code_next = CODE_FIRST;
                        width_next = START_WIDTH;
                        prev_valid_next = 1'b0;
                    end
                    else if (code13 >= 13'(TABLE_ENTRIES) || code13 > next_code_reg
                             || (kwkwk && !prev_valid_reg))
                    begin
                        halt_next = H_CORRUPT;
                    end
                    else
                    begin
                        add = kwkwk || (prev_valid_reg
                                        && next_code_reg < 13'(TABLE_ENTRIES));
                        nc_after = next_code_reg + 13'(add);
                        cmd_push = 1'b1;
                        cmd.kwkwk = kwkwk;
                        cmd.add = add;
                        cmd.walk_code = kwkwk ? prev_reg : code;
                        cmd.add_addr = next_code_reg[CODE_BITS-1:0];
                        cmd.add_prefix = prev_reg;
                        next_code_next = nc_after;
                        prev_next = code;
                        prev_valid_next = 1'b1;
                        if (({1'b0, nc_after} + 14'd1) >= (14'(1) << width_reg)
                            && width_reg < 4'(MAX_CODE_BITS))
                        begin
                            width_next = width_reg + 4'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitbuf_reg <= '0;
            bitcnt_reg <= '0;
            next_code_reg <= CODE_FIRST;
            width_reg <= START_WIDTH;
            prev_reg <= '0;
            prev_valid_reg <= 1'b0;
            halt_reg <= H_DECODING;
        end
        else
        begin
            bitbuf_reg <= bitbuf_next;
            bitcnt_reg <= bitcnt_next;
            next_code_reg <= next_code_next;
            width_reg <= width_next;
            prev_reg <= prev_next;
            prev_valid_reg <= prev_valid_next;
            halt_reg <= halt_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lzwd_cmd_queue.sv
// Short command queue between the front end and the expansion engine.
`default_nettype none
module lzwd_cmd_queue import lzwd_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  cmd_t      wdata,
    output logic      full,
    input  wire logic rd,
    output cmd_t      rdata,
    output logic      empty
);

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    cmd_t            slot_reg [DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [PW:0]     count_reg;

    assign full = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr && !full)
            begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (rd && !empty)
            begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(wr && !full) - (PW+1)'(rd && !empty);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lzwd_back.sv
// Expansion engine: prefix chain walk, byte reversal, result packing.
`default_nettype none
module lzwd_back import lzwd_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  cmd_t      cmd,
    input  wire logic cmd_empty,
    output logic      cmd_pop,
    output logic      out_valid,
    output out_t      out_item,
    input  wire logic out_pop
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WALK   = 6'b000010,
        S_POP    = 6'b000100,
        S_EXTRA  = 6'b001000,
        S_FLUSH  = 6'b010000,
        S_STATUS = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [CODE_BITS-1:0] c_reg, c_next;
    logic [AW-1:0] depth_reg, depth_next;
    logic   rd_pend_reg, rd_pend_next;
    logic [7:0] root_reg, root_next;
    logic [511:0] asm_reg, asm_next;
    logic [6:0] asm_cnt_reg, asm_cnt_next;
    logic [31:0] total_reg, total_next;
    logic   out_valid_reg, out_valid_next;
    out_t   out_reg, out_next;

    logic tbl_re, tbl_we, stk_re, stk_we;
    logic [AW-1:0] tbl_raddr, stk_raddr;
    logic [CODE_BITS-1:0] prefix_rd;
    logic [7:0] tail_rd, stk_rd;

    logic out_free, room, appended, load, load_last;
    logic [7:0] app_byte;
    logic app;

    lzwd_ram #(.WIDTH(CODE_BITS), .DEPTH(TABLE_ENTRIES)) u_prefix (
        .clk(clk), .we(tbl_we), .waddr(cmd_reg.add_addr[AW-1:0]),
        .wdata(cmd_reg.add_prefix), .re(tbl_re), .raddr(tbl_raddr), .rdata(prefix_rd)
    );

    lzwd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_tail (
        .clk(clk), .we(tbl_we), .waddr(cmd_reg.add_addr[AW-1:0]),
        .wdata(c_reg[7:0]), .re(tbl_re), .raddr(tbl_raddr), .rdata(tail_rd)
    );

    lzwd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(depth_reg), .wdata(tail_rd),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
    );

    assign out_free = !out_valid_reg || out_pop;
    assign room = (asm_cnt_reg != 7'(BYTES_PER_RESULT));
    assign out_valid = out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        c_next = c_reg;
        depth_next = depth_reg;
        rd_pend_next = rd_pend_reg;
        root_next = root_reg;
        asm_next = asm_reg;
        asm_cnt_next = asm_cnt_reg;
        total_next = total_reg;
        out_valid_next = out_valid_reg && !out_pop;
        out_next = out_reg;
        cmd_pop = 1'b0;
        tbl_re = 1'b0;
        tbl_we = 1'b0;
        tbl_raddr = c_reg[AW-1:0];
        stk_re = 1'b0;
        stk_we = 1'b0;
        stk_raddr = depth_reg - AW'(1);
        app = 1'b0;
        app_byte = stk_rd;
        appended = 1'b0;
        load = 1'b0;
        load_last = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    cmd_next = cmd;
                    if (cmd.kind == CMD_STATUS)
                    begin
                        state_next = S_STATUS;
                    end
                    else
                    begin
                        c_next = cmd.walk_code;
                        tbl_re = 1'b1;
                        tbl_raddr = cmd.walk_code[AW-1:0];
                        depth_next = '0;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if ({1'b0, c_reg} >= CODE_FIRST)
                begin
                    stk_we = 1'b1;
                    depth_next = depth_reg + AW'(1);
                    c_next = prefix_rd;
                    tbl_re = 1'b1;
                    tbl_raddr = prefix_rd[AW-1:0];
                end
                else
                begin
                    root_next = c_reg[7:0];
                    tbl_we = cmd_reg.add;
                    app = 1'b1;
                    app_byte = c_reg[7:0];
                    rd_pend_next = 1'b0;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (rd_pend_reg && room)
                begin
                    app = 1'b1;
                    appended = 1'b1;
                    rd_pend_next = 1'b0;
                end
                else if (rd_pend_reg && out_free)
                begin
                    load = 1'b1;
                end
                if (depth_reg != '0 && (!rd_pend_reg || appended))
                begin
                    stk_re = 1'b1;
                    depth_next = depth_reg - AW'(1);
                    rd_pend_next = 1'b1;
                end
                if (depth_reg == '0 && !rd_pend_reg)
                begin
                    state_next = cmd_reg.kwkwk ? S_EXTRA : S_FLUSH;
                end
            end
            S_EXTRA:
            begin
                if (room)
                begin
                    app = 1'b1;
                    app_byte = root_reg;
                    state_next = S_FLUSH;
                end
                else if (out_free)
                begin
                    load = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    load_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.last_of_run = 1'b1;
                    out_next.final_status = cmd_reg.status;
                    out_next.total_bytes = total_reg;
                    total_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (app)
        begin
            asm_next[{asm_cnt_reg[5:0], 3'b000} +: 8] = app_byte;
            asm_cnt_next = asm_cnt_reg + 7'd1;
            if (total_reg != '1)
            begin
                total_next = total_reg + 32'd1;
            end
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            out_next.out_word_0 = asm_reg[63:0];
            out_next.out_word_1 = asm_reg[127:64];
            out_next.out_word_2 = asm_reg[191:128];
            out_next.out_word_3 = asm_reg[255:192];
            out_next.out_word_4 = asm_reg[319:256];
            out_next.out_word_5 = asm_reg[383:320];
            out_next.out_word_6 = asm_reg[447:384];
            out_next.out_word_7 = asm_reg[511:448];
            out_next.byte_count = asm_cnt_reg;
            out_next.last_of_run = load_last;
            out_next.final_status = ST_RUNNING;
            out_next.total_bytes = '0;
            asm_next = '0;
            asm_cnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        c_reg <= c_next;
        root_reg <= root_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            rd_pend_reg <= 1'b0;
            asm_reg <= '0;
            asm_cnt_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            rd_pend_reg <= rd_pend_next;
            asm_reg <= asm_next;
            asm_cnt_reg <= asm_cnt_next;
            total_reg <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pop) |=> $stable(out_reg))
        else $error("held result changed");

    a_asm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        asm_cnt_reg <= 7'(BYTES_PER_RESULT))
        else $error("packing buffer overrun");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (asm_cnt_reg == '0 && !rd_pend_reg))
        else $error("bytes left over between codes");

endmodule
`default_nettype wire

### hw/rtl/lzw_msb_early_change_decoder.sv
// LZW decoder top level, MSB-first codes with early width change.
// One compressed byte is accepted per cycle while the four-entry command
// queue is not full; the front end keeps code width, next code and halt
// state itself. The expansion engine handles a data code in steps: a
// dispatch, the walk along the prefix chain, a pop of each byte from the
// reversal stack and a drain, and a final flush. A KwKwK code adds a step
// that appends the first byte again, a full 64-byte result is handed on
// mid-string when the buffer fills, and the engine stalls while the result
// register is not taken. A status item is dispatched, then sent as a result.
// Tables are not cleared after reset; no clearing pass is needed.
`default_nettype none
module lzw_msb_early_change_decoder import lzwd_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  in_t       item,
    output logic      empty,
    input  wire logic pop,
    output out_t      result
);

    logic accept;
    logic cmd_wr, cmd_rd, cmd_empty, out_valid;
    cmd_t cmd_in, cmd_out;

    assign accept = push && !full;
    assign empty = !out_valid;

    lzwd_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept), .item(item),
        .cmd_push(cmd_wr), .cmd(cmd_in)
    );

    lzwd_cmd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(cmd_wr), .wdata(cmd_in), .full(full),
        .rd(cmd_rd), .rdata(cmd_out), .empty(cmd_empty)
    );

    lzwd_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_out), .cmd_empty(cmd_empty),
        .cmd_pop(cmd_rd), .out_valid(out_valid), .out_item(result), .out_pop(pop)
    );

endmodule
`default_nettype wire
